### hdl/ncf_pkg.sv
// Shared constants and payload types of the negative cycle finder.
package ncf_pkg;

  localparam int unsigned MaxNodes  = 32;
  localparam int unsigned MaxEdges  = 1024;
  localparam int unsigned DistBits  = 48;
  localparam int unsigned NodeW     = 6;
  localparam int unsigned WeightW   = 32;
  localparam int unsigned EdgeAddrW = $clog2(MaxEdges);
  localparam int unsigned EdgeCntW  = EdgeAddrW + 1;

  typedef struct packed {
    logic [NodeW-1:0]          edge_source;
    logic [NodeW-1:0]          edge_target;
    logic signed [WeightW-1:0] edge_weight;
    logic                      last_edge;
  } ncf_req_t;

  typedef struct packed {
    logic             cycle_found;
    logic [NodeW-1:0] cycle_node;
    logic             last_result;
  } ncf_res_t;

  typedef struct packed {
    logic [NodeW-1:0]          src;
    logic [NodeW-1:0]          dst;
    logic signed [WeightW-1:0] weight;
  } ncf_edge_t;

endpackage

### hdl/ncf_sat_add.sv
// Saturating addition of an edge weight to a node distance.
module ncf_sat_add (
  input  logic signed [ncf_pkg::DistBits-1:0] dist_i,
  input  logic signed [ncf_pkg::WeightW-1:0]  weight_i,
  output logic signed [ncf_pkg::DistBits-1:0] sum_o
);
  import ncf_pkg::*;

  logic signed [DistBits:0] dist_ext;
  logic signed [DistBits:0] weight_ext;
  logic signed [DistBits:0] full;

  assign dist_ext   = {dist_i[DistBits-1], dist_i};
  assign weight_ext = {{(DistBits + 1 - WeightW){weight_i[WeightW-1]}}, weight_i};
  assign full       = dist_ext + weight_ext;

  // The two top bits differ only when the sum has left the distance range.
  always_comb begin
    if (full[DistBits] != full[DistBits-1]) begin
      sum_o = full[DistBits] ? {1'b1, {(DistBits-1){1'b0}}} : {1'b0, {(DistBits-1){1'b1}}};
    end else begin
      sum_o = full[DistBits-1:0];
    end
  end

endmodule

### hdl/negative_cycle_finder_unit.sv
// Top level: edge loading, Bellman-Ford relaxation and negative cycle read-out.
//
//  Channel   Direction  Handshake                      Payload
//  config    in/out     APB write on psel&penable&pwrite  node_count in pwdata[5:0]
//  request   in         start high while busy is low   req_i (edge fields)
//  result    out        res_valid_o, one-cycle strobe  res_o (cycle fields)
//
// A request without last_edge is stored while the edge list has room, and busy stays low.
// The last edge starts the job: each of the n rounds fetches every stored edge
// through the single edge memory port and, for an edge with valid endpoints,
// reads both endpoint distances and writes the target back to the distance memory.
// The back walk and cycle collection read and check a parent for each step, and
// results come from the cycle buffer; the receiver cannot stall the results.
// Reset empties the edge list and sets node_count to 32; no clearing pass is run.
module negative_cycle_finder_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  ncf_pkg::ncf_req_t      req_i,
  output logic                   res_valid_o,
  output ncf_pkg::ncf_res_t      res_o
);
  import ncf_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_FETCH   = 4'd2;
  localparam logic [3:0] S_EDGE    = 4'd3;
  localparam logic [3:0] S_DIST    = 4'd4;
  localparam logic [3:0] S_CHECK   = 4'd5;
  localparam logic [3:0] S_BW_RD   = 4'd6;
  localparam logic [3:0] S_BW_CHK  = 4'd7;
  localparam logic [3:0] S_COL_ST  = 4'd8;
  localparam logic [3:0] S_COL_RD  = 4'd9;
  localparam logic [3:0] S_COL_CHK = 4'd10;
  localparam logic [3:0] S_ERD     = 4'd11;
  localparam logic [3:0] S_EOUT    = 4'd12;

  logic [3:0]          state_q, state_d;
  logic [NodeW-1:0]    node_count_q;
  logic [NodeW-1:0]    n_q, n_d;
  logic [EdgeCntW-1:0] edge_total_q, edge_total_d;
  logic [EdgeCntW-1:0] k_q, k_d;
  logic [NodeW-1:0]    r_q, r_d;
  logic [NodeW-1:0]    lu_q, lu_d;
  logic [NodeW-1:0]    x_q, x_d;
  logic [NodeW-1:0]    node_q, node_d;
  logic [NodeW-1:0]    cnt_q, cnt_d;
  logic [NodeW-1:0]    len_q, len_d;
  logic [MaxNodes:0]   vld_q, vld_d;
  logic                res_valid_q, res_valid_d;
  ncf_res_t            res_q, res_d;
  logic [NodeW-1:0]    par_addr_q;

  // Memories.
  ncf_edge_t                  edge_mem [MaxEdges];
  logic signed [DistBits-1:0] dist_mem [MaxNodes+1];
  logic [NodeW-1:0]           par_mem  [MaxNodes+1];
  logic [NodeW-1:0]           cyc_mem  [MaxNodes+1];

  logic                       edge_we, edge_re;
  ncf_edge_t                  edge_rd;
  logic                       dist_re, dist_we;
  logic signed [DistBits-1:0] dist_a_rd, dist_b_rd, dist_wd;
  logic                       par_re, par_we;
  logic [NodeW-1:0]           par_ra, par_rd;
  logic                       cyc_we, cyc_re;
  logic [NodeW-1:0]           cyc_wa, cyc_wd, cyc_ra, cyc_rd;

  logic                       accept;
  logic                       cfg_write;
  logic [NodeW-1:0]           n_eff;
  logic                       in_range;
  logic signed [DistBits-1:0] dist_a, dist_b, cand;
  logic [NodeW-1:0]           par_val;

  assign pready    = 1'b1;
  assign prdata    = (paddr == 2'd0) ? {{(32 - NodeW){1'b0}}, node_count_q} : '0;
  // There is a single register, so every write lands in node_count.
  assign cfg_write = psel & penable & pwrite & pready;
  assign busy      = (state_q != S_IDLE);
  assign accept    = start & ~busy;

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = NodeW'(1);
    end else if (node_count_q > NodeW'(MaxNodes)) begin
      n_eff = NodeW'(MaxNodes);
    end else begin
      n_eff = node_count_q;
    end
  end

  assign in_range = (edge_rd.src != '0) && (edge_rd.src <= n_q) &&
                    (edge_rd.dst != '0) && (edge_rd.dst <= n_q);

  // Entries not yet written in this job read as distance zero and no parent.
  assign dist_a  = vld_q[edge_rd.src] ? dist_a_rd : '0;
  assign dist_b  = vld_q[edge_rd.dst] ? dist_b_rd : '0;
  assign par_val = vld_q[par_addr_q] ? par_rd : '0;

  ncf_sat_add u_sat_add (
    .dist_i   (dist_a),
    .weight_i (edge_rd.weight),
    .sum_o    (cand)
  );

  assign dist_wd = cand;

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    edge_total_d = edge_total_q;
    k_d          = k_q;
    r_d          = r_q;
    lu_d         = lu_q;
    x_d          = x_q;
    node_d       = node_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    vld_d        = vld_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    edge_we      = 1'b0;
    edge_re      = 1'b0;
    dist_re      = 1'b0;
    dist_we      = 1'b0;
    par_re       = 1'b0;
    par_we       = 1'b0;
    par_ra       = x_q;
    cyc_we       = 1'b0;
    cyc_wa       = len_q;
    cyc_wd       = x_q;
    cyc_re       = 1'b0;
    cyc_ra       = len_q - NodeW'(1);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (edge_total_q < EdgeCntW'(MaxEdges)) begin
            edge_we      = 1'b1;
            edge_total_d = edge_total_q + EdgeCntW'(1);
          end
          if (req_i.last_edge) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        vld_d   = '0;
        lu_d    = '0;
        r_d     = '0;
        k_d     = '0;
        n_d     = n_eff;
        state_d = S_FETCH;
      end
      S_FETCH: begin
        if (k_q == edge_total_q) begin
          if (r_q == n_q - NodeW'(1)) begin
            edge_total_d = '0;
            state_d      = S_CHECK;
          end else begin
            r_d  = r_q + NodeW'(1);
            k_d  = '0;
            lu_d = '0;
          end
        end else begin
          edge_re = 1'b1;
          k_d     = k_q + EdgeCntW'(1);
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        if (in_range) begin
          dist_re = 1'b1;
          state_d = S_DIST;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_DIST: begin
        if (dist_b > cand) begin
          dist_we             = 1'b1;
          par_we              = 1'b1;
          vld_d[edge_rd.dst]  = 1'b1;
          lu_d                = edge_rd.dst;
        end
        state_d = S_FETCH;
      end
      S_CHECK: begin
        if (lu_q == '0) begin
          res_valid_d = 1'b1;
          res_d       = '{cycle_found: 1'b0, cycle_node: '0, last_result: 1'b1};
          state_d     = S_IDLE;
        end else begin
          x_d     = lu_q;
          cnt_d   = '0;
          state_d = S_BW_RD;
        end
      end
      S_BW_RD: begin
        if (cnt_q == n_q) begin
          state_d = S_COL_ST;
        end else begin
          par_re  = 1'b1;
          par_ra  = x_q;
          state_d = S_BW_CHK;
        end
      end
      S_BW_CHK: begin
        if (par_val == '0) begin
          state_d = S_COL_ST;
        end else begin
          x_d     = par_val;
          cnt_d   = cnt_q + NodeW'(1);
          state_d = S_BW_RD;
        end
      end
      S_COL_ST: begin
        cyc_we  = 1'b1;
        cyc_wa  = '0;
        cyc_wd  = x_q;
        node_d  = x_q;
        len_d   = NodeW'(1);
        cnt_d   = '0;
        state_d = S_COL_RD;
      end
      S_COL_RD: begin
        if (cnt_q == n_q) begin
          state_d = S_ERD;
        end else begin
          par_re  = 1'b1;
          par_ra  = node_q;
          state_d = S_COL_CHK;
        end
      end
      S_COL_CHK: begin
        if (par_val == '0) begin
          state_d = S_ERD;
        end else begin
          cyc_we = 1'b1;
          cyc_wa = len_q;
          cyc_wd = par_val;
          len_d  = len_q + NodeW'(1);
          node_d = par_val;
          cnt_d  = cnt_q + NodeW'(1);
          state_d = (par_val == x_q) ? S_ERD : S_COL_RD;
        end
      end
      S_ERD: begin
        cyc_re  = 1'b1;
        cyc_ra  = len_q - NodeW'(1);
        state_d = S_EOUT;
      end
      S_EOUT: begin
        res_valid_d = 1'b1;
        res_d       = '{cycle_found: 1'b1, cycle_node: cyc_rd,
                        last_result: (len_q == NodeW'(1))};
        len_d       = len_q - NodeW'(1);
        state_d     = (len_q == NodeW'(1)) ? S_IDLE : S_ERD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NodeW'(MaxNodes);
      n_q          <= NodeW'(1);
      edge_total_q <= '0;
      k_q          <= '0;
      r_q          <= '0;
      lu_q         <= '0;
      x_q          <= '0;
      node_q       <= '0;
      cnt_q        <= '0;
      len_q        <= '0;
      vld_q        <= '0;
      res_valid_q  <= 1'b0;
      par_addr_q   <= '0;
    end else begin
      state_q      <= state_d;
      if (cfg_write) begin
        node_count_q <= pwdata[NodeW-1:0];
      end
      n_q          <= n_d;
      edge_total_q <= edge_total_d;
      k_q          <= k_d;
      r_q          <= r_d;
      lu_q         <= lu_d;
      x_q          <= x_d;
      node_q       <= node_d;
      cnt_q        <= cnt_d;
      len_q        <= len_d;
      vld_q        <= vld_d;
      res_valid_q  <= res_valid_d;
      if (par_re) begin
        par_addr_q <= par_ra;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Edge list memory.
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_total_q[EdgeAddrW-1:0]] <= '{src: req_i.edge_source,
                                                 dst: req_i.edge_target,
                                                 weight: req_i.edge_weight};
    end
    if (edge_re) begin
      edge_rd <= edge_mem[k_q[EdgeAddrW-1:0]];
    end
  end

  // Distance memory: both endpoints are read together, the target written back.
  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[edge_rd.dst] <= dist_wd;
    end
    if (dist_re) begin
      dist_a_rd <= dist_mem[edge_rd.src];
      dist_b_rd <= dist_mem[edge_rd.dst];
    end
  end

  // Parent memory.
  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[edge_rd.dst] <= edge_rd.src;
    end
    if (par_re) begin
      par_rd <= par_mem[par_ra];
    end
  end

  // Cycle buffer, collected backwards and read out in forward order.
  always_ff @(posedge clk_i) begin
    if (cyc_we) begin
      cyc_mem[cyc_wa] <= cyc_wd;
    end
    if (cyc_re) begin
      cyc_rd <= cyc_mem[cyc_ra];
    end
  end

  a_no_cycle_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.cycle_found) |-> (res_o.last_result && res_o.cycle_node == '0))
    else $error("no-cycle result is not a single closing result");

  a_res_spacing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("results strobed on consecutive cycles");

  a_relax_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIST) |-> (edge_rd.dst != '0 && edge_rd.dst <= n_q &&
                             edge_rd.src != '0 && edge_rd.src <= n_q))
    else $error("relaxation on an endpoint outside the node range");

  a_edge_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= EdgeCntW'(MaxEdges))
    else $error("edge count above memory depth");

  a_job_clears_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (edge_total_q == '0))
    else $error("edge list not emptied at the end of relaxation");

endmodule

### dv/tb.sv
// Testbench for the negative cycle finder: directed and random edge lists checked by a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncf_pkg::*;

  localparam logic [1:0]  NodeCountAddr = 2'd0;
  localparam int unsigned StallLimit    = 40000;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned MaxReports    = 10;
  localparam logic [31:0] WeightMin     = 32'h8000_0000;
  localparam logic [31:0] WeightMax     = 32'h7fff_ffff;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [1:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start   = 1'b0;
  logic        busy;
  ncf_req_t    edge_req = '0;
  logic        res_valid;
  ncf_res_t    cycle_res;

  always #2 clk_i = ~clk_i;

  negative_cycle_finder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start      (start),
    .busy       (busy),
    .req_i      (edge_req),
    .res_valid_o(res_valid),
    .res_o      (cycle_res)
  );

  ncf_edge_t        edge_list[$];
  ncf_res_t         expected_nodes[$];
  ncf_res_t         next_expected;
  logic [NodeW-1:0] node_count_reg  = 6'd32;
  int unsigned      sender_idle_pct = 0;
  int unsigned      items_sent      = 0;
  int unsigned      mismatches      = 0;
  int unsigned      stall_cycles    = 0;

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("MISMATCH: %s", msg);
  endfunction

  function automatic int unsigned effective_nodes();
    if (node_count_reg == 0) return 1;
    if (node_count_reg > MaxNodes) return MaxNodes;
    return node_count_reg;
  endfunction

  function automatic longint clamp_sum(input longint base, input longint step);
    longint hi, lo;
    hi = (longint'(1) <<< (DistBits - 1)) - 1;
    lo = -hi - 1;
    if (step > 0 && base > hi - step) return hi;
    if (step < 0 && base < lo - step) return lo;
    return base + step;
  endfunction

  // Runs the relaxation rounds over the stored edges and queues the cycle read-out or a single no-cycle result.
  function automatic void predict_cycle_search();
    int unsigned n, a, b, x, node, upd;
    longint      dist_now[MaxNodes + 1];
    int unsigned parent[MaxNodes + 1];
    int unsigned loop_nodes[$];
    longint      cand;
    n = effective_nodes();
    foreach (dist_now[i]) begin
      dist_now[i] = 0;
      parent[i]   = 0;
    end
    upd = 0;
    for (int r = 0; r < n; r++) begin
      upd = 0;
      foreach (edge_list[k]) begin
        a = edge_list[k].src;
        b = edge_list[k].dst;
        if (a == 0 || a > n || b == 0 || b > n) continue;
        cand = clamp_sum(dist_now[a], {{32{edge_list[k].weight[31]}}, edge_list[k].weight});
        if (dist_now[b] > cand) begin
          dist_now[b] = cand;
          parent[b]   = a;
          upd         = b;
        end
      end
    end
    edge_list.delete();
    if (upd == 0) begin
      expected_nodes.insert(expected_nodes.size(),
                            '{cycle_found: 1'b0, cycle_node: '0, last_result: 1'b1});
      return;
    end
    // Walk back far enough to be sure of standing on the cycle itself.
    x = upd;
    for (int i = 0; i < n; i++) begin
      if (parent[x] == 0) break;
      x = parent[x];
    end
    loop_nodes.insert(loop_nodes.size(), x);
    node = x;
    for (int i = 0; i < n; i++) begin
      node = parent[node];
      if (node == 0) break;
      loop_nodes.insert(loop_nodes.size(), node);
      if (node == x) break;
    end
    for (int i = loop_nodes.size() - 1; i >= 0; i--) begin
      expected_nodes.insert(expected_nodes.size(),
                            '{cycle_found: 1'b1, cycle_node: NodeW'(loop_nodes[i]),
                              last_result: (i == 0)});
    end
  endfunction

  function automatic void record_edge(input ncf_req_t item);
    if (edge_list.size() < MaxEdges) begin
      edge_list.insert(edge_list.size(), '{src: item.edge_source, dst: item.edge_target,
                                           weight: item.edge_weight});
    end
    if (item.last_edge) predict_cycle_search();
  endfunction

  function automatic ncf_req_t make_edge(input int unsigned s, input int unsigned d,
                                         input int w, input logic last);
    ncf_req_t item;
    item.edge_source = NodeW'(s);
    item.edge_target = NodeW'(d);
    item.edge_weight = w;
    item.last_edge   = last;
    return item;
  endfunction

  function automatic int unsigned pick_node(input int unsigned n);
    if ($urandom_range(9) == 0) return $urandom_range(63);
    return $urandom_range(n, 1);
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(9))
      0: return $urandom;
      1: return WeightMin;
      2: return WeightMax;
      default: return 32'($urandom_range(60)) - 32'd20;
    endcase
  endfunction

  task automatic send_edge(input ncf_req_t item);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    edge_req <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
    record_edge(item);
  endtask

  // Holds requests off until every expected result has arrived and the block has settled.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_nodes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= NodeCountAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_node_count(input logic [NodeW-1:0] value);
    logic [31:0] wdata, rdata;
    wdata = $urandom;
    wdata[NodeW-1:0] = value;
    apb_access(1'b1, wdata, rdata);
    node_count_reg = value;
    apb_access(1'b0, '0, rdata);
    if (rdata[NodeW-1:0] !== value) begin
      note_mismatch($sformatf("node_count read back %0d, expected %0d",
                              rdata[NodeW-1:0], value));
    end
  endtask

  task automatic send_random_job();
    int unsigned n, ring_len, extra;
    int          ring_sum, w;
    int unsigned ring[$];
    ncf_req_t    job[$];
    ncf_req_t    item;
    n = effective_nodes();
    // Most jobs carry a planted negative cycle among random extra edges.
    if ($urandom_range(2) != 0) begin
      ring_len = ($urandom_range(9) == 0) ? n : $urandom_range((n < 6) ? n : 6, 1);
      for (int i = 0; i < ring_len; i++) ring.insert(ring.size(), $urandom_range(n, 1));
      ring_sum = 0;
      for (int i = 0; i < ring_len; i++) begin
        if (i == ring_len - 1) w = -ring_sum - int'($urandom_range(50, 1));
        else w = int'($urandom_range(80)) - 40;
        ring_sum += w;
        job.insert(job.size(), make_edge(ring[i], ring[(i + 1) % ring_len], w, 1'b0));
      end
    end
    extra = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(8);
    if (job.size() == 0 && extra == 0) extra = 1;
    repeat (extra) begin
      job.insert($urandom_range(job.size()),
                 make_edge(pick_node(n), pick_node(n), pick_weight(), 1'b0));
    end
    for (int i = 0; i < job.size(); i++) begin
      item = job[i];
      item.last_edge = (i == job.size() - 1);
      send_edge(item);
    end
  endtask

  task automatic test_register_reset();
    logic [31:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[NodeW-1:0] !== NodeW'(MaxNodes)) begin
      note_mismatch($sformatf("node_count after reset %0d", rdata[NodeW-1:0]));
    end
  endtask

  task automatic test_single_edges();
    sender_idle_pct = 28;
    send_edge(make_edge(1, 2, 5, 1'b1));
    send_edge(make_edge(63, 1, WeightMin, 1'b0));
    send_edge(make_edge(0, 5, WeightMin, 1'b0));
    send_edge(make_edge(32, 1, WeightMax, 1'b0));
    send_edge(make_edge(1, 32, 32'hffff_ffff, 1'b0));
    send_edge(make_edge(32, 32, 0, 1'b1));
    wait_idle();
  endtask

  task automatic test_negative_cycles();
    send_edge(make_edge(1, 2, 2, 1'b0));
    send_edge(make_edge(2, 3, -4, 1'b0));
    send_edge(make_edge(3, 1, 1, 1'b1));
    wait_idle();
    send_edge(make_edge(5, 5, -1, 1'b1));
    send_edge(make_edge(7, 8, 3, 1'b0));
    send_edge(make_edge(8, 7, -3, 1'b1));
    send_edge(make_edge(1, 2, WeightMin, 1'b0));
    send_edge(make_edge(2, 1, WeightMax, 1'b1));
    wait_idle();
  endtask

  task automatic test_node_count_limits();
    set_node_count(6'd1);
    send_edge(make_edge(1, 1, -3, 1'b1));
    send_edge(make_edge(2, 2, -3, 1'b0));
    send_edge(make_edge(1, 2, -1, 1'b1));
    wait_idle();
    // Zero is taken as a single node, anything above the maximum as the maximum.
    set_node_count(6'd0);
    send_edge(make_edge(1, 1, -1, 1'b1));
    wait_idle();
    set_node_count(6'd63);
    send_edge(make_edge(32, 1, -1, 1'b0));
    send_edge(make_edge(1, 32, -1, 1'b1));
    wait_idle();
  endtask

  task automatic test_endpoints_out_of_range();
    set_node_count(6'd4);
    send_edge(make_edge(0, 1, -5, 1'b0));
    send_edge(make_edge(1, 0, -5, 1'b0));
    send_edge(make_edge(5, 1, -5, 1'b0));
    send_edge(make_edge(1, 5, -5, 1'b0));
    send_edge(make_edge(63, 63, WeightMin, 1'b0));
    send_edge(make_edge(2, 2, -1, 1'b1));
    wait_idle();
  endtask

  task automatic test_random_jobs(input int unsigned idle_pct, input int unsigned item_goal);
    int unsigned goal;
    sender_idle_pct = idle_pct;
    goal = items_sent + item_goal;
    while (items_sent < goal) begin
      case ($urandom_range(7))
        0: begin
          wait_idle();
          case ($urandom_range(5))
            0: set_node_count(6'd0);
            1: set_node_count(6'd1);
            2: set_node_count(NodeW'(MaxNodes));
            3: set_node_count(NodeW'($urandom_range(63, MaxNodes + 1)));
            default: set_node_count(NodeW'($urandom_range(MaxNodes, 1)));
          endcase
        end
        1: wait_idle();
        default: ;
      endcase
      send_random_job();
    end
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid) stall_cycles = 0;
    else stall_cycles++;
    if (rst_ni && res_valid) begin
      if (expected_nodes.size() == 0) begin
        note_mismatch($sformatf("unexpected result: found %0b node %0d last %0b",
                                cycle_res.cycle_found, cycle_res.cycle_node,
                                cycle_res.last_result));
      end else begin
        next_expected = expected_nodes.pop_front();
        if (cycle_res.cycle_found !== next_expected.cycle_found ||
            cycle_res.cycle_node !== next_expected.cycle_node ||
            cycle_res.last_result !== next_expected.last_result) begin
          note_mismatch($sformatf(
            "expected found %0b node %0d last %0b, got found %0b node %0d last %0b",
            next_expected.cycle_found, next_expected.cycle_node, next_expected.last_result,
            cycle_res.cycle_found, cycle_res.cycle_node, cycle_res.last_result));
        end
      end
    end
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < StallLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_reset();
    test_single_edges();
    test_negative_cycles();
    test_node_count_limits();
    test_endpoints_out_of_range();
    test_random_jobs(28, 100);
    test_random_jobs(84, 100);
    test_random_jobs(0, 100);
    wait_idle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### negative_cycle_finder_unit.f
hdl/ncf_pkg.sv
hdl/ncf_sat_add.sv
hdl/negative_cycle_finder_unit.sv
dv/tb.sv
